[rtl/smt_pkg.sv]
// Shared types and constants for the slot multiset table.
`timescale 1ns / 1ps

package smt_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;  // clear one slot during the post-reset sweep
        logic load;        // capture an input transaction, restart the scan
        logic scan_step;   // issue the next read and check the previous one
        logic publish;     // update the count and load the result registers
    } smt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;  // the slot being cleared is the last one
        logic scan_done;   // no read in flight and nothing left to read
    } smt_status_t;

endpackage

[rtl/smt_datapath.sv]
// Datapath of the slot multiset table: slot memory, scan pipeline, counts, result registers.
`timescale 1ns / 1ps

module smt_datapath #(
    parameter int SLOTS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  smt_pkg::smt_cmd_t                 cmd,
    output smt_pkg::smt_status_t              status,
    input  logic                              in_operation,
    input  logic [smt_pkg::VALUE_W-1:0]       in_value,
    output logic                              out_accepted,
    output logic [smt_pkg::COUNT_W-1:0]       out_removed_count,
    output logic [smt_pkg::COUNT_W-1:0]       out_stored_count
);
    import smt_pkg::*;

    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRY_W = VALUE_W + 1;  // occupied bit on top of the value

    // Slot memory: {occupied, value}
    logic [ENTRY_W-1:0] mem [SLOTS];

    logic [ENTRY_W-1:0] rd_data_reg;
    logic               cmp_vld_reg,  cmp_vld_next;
    logic [ADDR_W-1:0]  cmp_idx_reg,  cmp_idx_next;
    logic [ADDR_W:0]    issue_idx_reg, issue_idx_next;
    logic [ADDR_W-1:0]  clr_idx_reg,  clr_idx_next;
    logic               op_reg;
    logic [VALUE_W-1:0] val_reg;
    logic               found_reg,    found_next;
    logic [COUNT_W-1:0] freed_reg,    freed_next;
    logic [COUNT_W-1:0] total_reg,    total_next;
    logic               acc_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] stored_reg;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               issue_left;
    logic               rd_occ;
    logic [VALUE_W-1:0] rd_val;

    assign rd_occ     = rd_data_reg[ENTRY_W-1];
    assign rd_val     = rd_data_reg[VALUE_W-1:0];
    assign issue_left = (issue_idx_reg != (ADDR_W+1)'(SLOTS)) && !found_reg;
    assign rd_addr    = issue_idx_reg[ADDR_W-1:0];

    assign status.clear_done = (clr_idx_reg == ADDR_W'(SLOTS - 1));
    assign status.scan_done  = !issue_left && !cmp_vld_reg;

    always_comb begin
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = clr_idx_reg;
        wr_data        = '0;
        clr_idx_next   = clr_idx_reg;
        issue_idx_next = issue_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        freed_next     = freed_reg;
        total_next     = total_reg;

        if (cmd.clear_step) begin
            wr_en        = 1'b1;
            clr_idx_next = clr_idx_reg + ADDR_W'(1);
        end

        if (cmd.load) begin
            issue_idx_next = '0;
            cmp_vld_next   = 1'b0;
            found_next     = 1'b0;
            freed_next     = '0;
        end

        if (cmd.scan_step) begin
            // read stage
            rd_en          = issue_left;
            cmp_vld_next   = issue_left;
            cmp_idx_next   = rd_addr;
            if (issue_left) begin
                issue_idx_next = issue_idx_reg + (ADDR_W+1)'(1);
            end
            // check stage on last cycle's read
            if (cmp_vld_reg) begin
                wr_addr = cmp_idx_reg;
                if (op_reg == OP_INSERT) begin
                    if (!rd_occ && !found_reg) begin
                        wr_en      = 1'b1;
                        wr_data    = {1'b1, val_reg};
                        found_next = 1'b1;
                    end
                end else begin
                    if (rd_occ && (rd_val == val_reg)) begin
                        wr_en      = 1'b1;
                        wr_data    = {1'b0, rd_val};
                        freed_next = freed_reg + COUNT_W'(1);
                    end
                end
            end
        end

        if (cmd.publish) begin
            if (op_reg == OP_INSERT) begin
                total_next = total_reg + COUNT_W'(found_reg);
            end else begin
                total_next = total_reg - freed_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg   <= '0;
            issue_idx_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            freed_reg     <= '0;
            total_reg     <= '0;
        end else begin
            clr_idx_reg   <= clr_idx_next;
            issue_idx_reg <= issue_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            freed_reg     <= freed_next;
            total_reg     <= total_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cmp_idx_next;
        if (cmd.load) begin
            op_reg  <= in_operation;
            val_reg <= in_value;
        end
        if (cmd.publish) begin
            acc_reg    <= (op_reg == OP_DELETE) || found_reg;
            rem_reg    <= (op_reg == OP_DELETE) ? freed_reg : '0;
            stored_reg <= total_next;
        end
    end

    assign out_accepted      = acc_reg;
    assign out_removed_count = rem_reg;
    assign out_stored_count  = stored_reg;

endmodule

[rtl/smt_ctrl.sv]
// Controller of the slot multiset table: clear sweep, scan sequencing, handshakes.
`timescale 1ns / 1ps

module smt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output smt_pkg::smt_cmd_t    cmd,
    input  smt_pkg::smt_status_t status
);
    import smt_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.load       = (state_reg == ST_IDLE) && s_valid;
        cmd.scan_step  = (state_reg == ST_SCAN);
        cmd.publish    = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (cmd.publish) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[rtl/slot_multiset_table.sv]
// Top level of the slot multiset table.
`timescale 1ns / 1ps

// Slot multiset table: SLOTS value slots, each with an occupied flag, hold a
// multiset of 32-bit values. An insert transaction writes its value into the
// lowest-numbered free slot; into a full table it is dropped and reported
// with accepted = 0. A delete transaction frees every occupied slot holding
// the value (bitwise compare) and reports how many. Each input transaction
// yields one result transaction carrying the occupied count after the
// operation; both counts are 5 bits and wrap modulo 32 when SLOTS > 31.
// Slots and flags live in one single-port-write, registered-read memory, so
// a transaction walks the slots one read per cycle: a delete, or an insert
// into a full table, reads every slot before its result; an insert stops
// issuing reads once it has written its value into a free slot. The next
// transaction is taken once the current result sits in the output register;
// a finished result waits while that register is still held by an
// unaccepted one. After reset the block clears the occupied flags of all
// slots, with s_ready low.

module slot_multiset_table #(
    parameter int SLOTS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input transactions
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic signed [smt_pkg::VALUE_W-1:0] s_value,
    // result transactions
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic [smt_pkg::COUNT_W-1:0]       m_removed_count,
    output logic [smt_pkg::COUNT_W-1:0]       m_stored_count
);
    import smt_pkg::*;

    smt_cmd_t    cmd;
    smt_status_t status;

    smt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    smt_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .in_operation      (s_operation),
        .in_value          (VALUE_W'(s_value)),
        .out_accepted      (m_accepted),
        .out_removed_count (m_removed_count),
        .out_stored_count  (m_stored_count)
    );

endmodule
